### rtl/qst_pkg.sv
// Shared types and constants for the query string tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package qst_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_AMP     = 8'h26;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       is_value;
      logic       token_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_PASS     = 2'd0,
      OP_MARK     = 2'd1,
      OP_ESC_HI   = 2'd2,
      OP_ESC_FULL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_PCT  = 3'b010,
      ESC_HIGH = 3'b100
   } esc_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] raw;
      logic [3:0] nibble;
      logic       is_value;
      logic       token_end;
   } cmd_type;

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

### rtl/query_string_tokenizer.sv
// Query string tokenizer: splits a URL query string into name and value tokens,
// decoding percent escapes in values. Depends on qst_pkg, qst_front, qst_queue, qst_back.
//
// Usage:
//   Input is a queue-style channel: present a byte and its last flag on req_data and
//   raise req_push; the transfer happens on a clock edge with req_push high and
//   req_full low. One byte per cycle is taken indefinitely while results drain.
//   Results come out of a queue-style channel: while rsp_empty is low the oldest
//   result sits on rsp_data; a transfer happens on an edge with rsp_pop high.
//   A byte yields zero or one result. The command is written into the queue at the
//   transfer edge and moves from the queue head into the result register whenever
//   that register is empty or being popped.
//   Throughput is one byte per cycle while req_full is low.
//   When the receiver stalls, commands collect in a QUEUE_DEPTH-entry queue plus the
//   result register; req_full rises once the queue is full.
//   Synchronous reset returns to reading a name with no escape pending and empties
//   the queue and result register. The state also returns there after a last byte.
`timescale 1ns / 1ps

module query_string_tokenizer import qst_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_payload_type req_data,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data
);

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   logic    q_nonempty;
   logic    q_take;
   cmd_type q_head;

   assign accept = req_push && !req_full;

   qst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   qst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_valid),
      .wr_data  (cmd),
      .full     (req_full),
      .rd_en    (q_take),
      .nonempty (q_nonempty),
      .rd_data  (q_head)
   );

   qst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (q_nonempty),
      .cmd       (q_head),
      .cmd_take  (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/qst_front.sv
// Front end: accepts bytes, tracks name/value and escape state, emits commands.
// Depends on qst_pkg.
`timescale 1ns / 1ps

module qst_front import qst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   output logic            cmd_valid,
   output cmd_type         cmd
);

   logic          value_ff, value_in;
   esc_state_type esc_ff, esc_in;
   logic [3:0]    nib_ff, nib_in;

   always_comb begin
      value_in  = value_ff;
      esc_in    = esc_ff;
      nib_in    = nib_ff;
      cmd_valid = 1'b0;
      cmd.op        = OP_PASS;
      cmd.raw       = req.in_byte;
      cmd.nibble    = nib_ff;
      cmd.is_value  = value_ff;
      cmd.token_end = req.in_last;
      if (accept) begin
         if (!value_ff) begin
            cmd_valid = 1'b1;
            if (req.in_byte == CH_EQUAL) begin
               cmd.op        = OP_MARK;
               cmd.token_end = 1'b1;
               value_in      = 1'b1;
               esc_in        = ESC_IDLE;
               nib_in        = 4'd0;
            end
         end else begin
            unique case (esc_ff)
               ESC_IDLE: begin
                  if (req.in_byte == CH_AMP) begin
                     cmd_valid     = 1'b1;
                     cmd.op        = OP_MARK;
                     cmd.token_end = 1'b1;
                     value_in      = 1'b0;
                  end else if (req.in_byte == CH_PERCENT) begin
                     esc_in     = ESC_PCT;
                     nib_in     = 4'd0;
                     cmd_valid  = req.in_last;
                     cmd.op     = OP_ESC_HI;
                     cmd.nibble = 4'd0;
                  end else begin
                     cmd_valid = 1'b1;
                  end
               end
               ESC_PCT, ESC_HIGH: begin
                  priority if (req.in_byte == CH_AMP) begin
                     cmd_valid     = 1'b1;
                     cmd.op        = OP_ESC_HI;
                     cmd.token_end = 1'b1;
                     value_in      = 1'b0;
                     esc_in        = ESC_IDLE;
                     nib_in        = 4'd0;
                  end else if (esc_ff == ESC_PCT) begin
                     nib_in     = hex_val(req.in_byte);
                     esc_in     = ESC_HIGH;
                     cmd_valid  = req.in_last;
                     cmd.op     = OP_ESC_HI;
                     cmd.nibble = hex_val(req.in_byte);
                  end else begin
                     cmd_valid = 1'b1;
                     cmd.op    = OP_ESC_FULL;
                     esc_in    = ESC_IDLE;
                     nib_in    = 4'd0;
                  end
               end
               default: begin
                  esc_in = ESC_IDLE;
               end
            endcase
         end
         if (req.in_last) begin
            value_in = 1'b0;
            esc_in   = ESC_IDLE;
            nib_in   = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= 1'b0;
         esc_ff   <= ESC_IDLE;
         nib_ff   <= 4'd0;
      end else begin
         value_ff <= value_in;
         esc_ff   <= esc_in;
         nib_ff   <= nib_in;
      end
   end

endmodule

### rtl/qst_queue.sv
// Short command queue between front and back ends.
// Depends on qst_pkg.
`timescale 1ns / 1ps

module qst_queue import qst_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    nonempty,
   output cmd_type rd_data
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(DEPTH);

   cmd_type               entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full     = (count_ff == DepthCnt);
   assign nonempty = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/qst_back.sv
// Back end: forms the decoded byte from a command and holds the result register.
// Depends on qst_pkg.
`timescale 1ns / 1ps

module qst_back import qst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_avail,
   input  cmd_type         cmd,
   output logic            cmd_take,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign cmd_take = cmd_avail && (!valid_ff || rsp_pop);

   always_comb begin
      data_in.is_value  = cmd.is_value;
      data_in.token_end = cmd.token_end;
      unique case (cmd.op)
         OP_PASS: begin
            data_in.out_byte = cmd.raw;
            data_in.has_byte = 1'b1;
         end
         OP_MARK: begin
            data_in.out_byte = 8'd0;
            data_in.has_byte = 1'b0;
         end
         OP_ESC_HI: begin
            data_in.out_byte = {cmd.nibble, 4'd0};
            data_in.has_byte = 1'b1;
         end
         OP_ESC_FULL: begin
            data_in.out_byte = {cmd.nibble, hex_val(cmd.raw)};
            data_in.has_byte = 1'b1;
         end
         default: begin
            data_in.out_byte = 8'd0;
            data_in.has_byte = 1'b0;
         end
      endcase
      valid_in = cmd_take || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

endmodule

### tb/sv/query_string_tokenizer_test.sv
// Self-checking testbench for query_string_tokenizer: directed and random query strings
// are pushed in, and each popped result is checked against a token and escape decoder.
// Depends on qst_pkg and the query_string_tokenizer RTL.
`timescale 1ns / 1ps

module query_string_tokenizer_test;
   import qst_pkg::*;

   localparam int ITEM_TARGET = 2000;
   localparam int CYCLE_LIMIT = 100_000;
   localparam int QUIET_FROM  = 900;
   localparam int QUIET_TO    = 1200;

   class token_scoreboard;
      rsp_payload_type expected_q[$];
      bit              in_value;
      esc_state_type   esc_state;
      logic [3:0]      hi_nibble;
      int              errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         in_value  = 1'b0;
         esc_state = ESC_IDLE;
         hi_nibble = 4'd0;
      endfunction

      function logic [3:0] nibble_of(input logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
         if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
         if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
         return 4'd0;
      endfunction

      function void expect_token(input logic [7:0] b, input logic has, input logic val,
                                 input logic fin);
         rsp_payload_type r;
         r.out_byte  = has ? b : 8'd0;
         r.has_byte  = has;
         r.is_value  = val;
         r.token_end = fin;
         expected_q.push_back(r);
      endfunction

      // one transfer on the input side
      function void note_byte(input req_payload_type item);
         logic [7:0] b;
         logic       fin;
         b   = item.in_byte;
         fin = item.in_last;
         if (!in_value) begin
            if (b == CH_EQUAL) begin
               expect_token(8'd0, 1'b0, 1'b0, 1'b1);
               in_value  = 1'b1;
               esc_state = ESC_IDLE;
               hi_nibble = 4'd0;
            end else begin
               expect_token(b, 1'b1, 1'b0, fin);
            end
         end else if (esc_state == ESC_IDLE) begin
            if (b == CH_AMP) begin
               expect_token(8'd0, 1'b0, 1'b1, 1'b1);
               in_value = 1'b0;
            end else if (b == CH_PERCENT) begin
               esc_state = ESC_PCT;
               hi_nibble = 4'd0;
               if (fin) expect_token(8'd0, 1'b1, 1'b1, 1'b1);
            end else begin
               expect_token(b, 1'b1, 1'b1, fin);
            end
         end else if (b == CH_AMP) begin
            // escape cut short by the separator
            expect_token({hi_nibble, 4'd0}, 1'b1, 1'b1, 1'b1);
            clear_state();
         end else if (esc_state == ESC_PCT) begin
            hi_nibble = nibble_of(b);
            esc_state = ESC_HIGH;
            if (fin) expect_token({hi_nibble, 4'd0}, 1'b1, 1'b1, 1'b1);
         end else begin
            expect_token({hi_nibble, nibble_of(b)}, 1'b1, 1'b1, fin);
            esc_state = ESC_IDLE;
            hi_nibble = 4'd0;
         end
         if (fin) clear_state();
      endfunction

      // one transfer on the result side
      function void check_result(input rsp_payload_type got);
         rsp_payload_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.out_byte !== exp_r.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h actual %h",
                     $time, exp_r.out_byte, got.out_byte);
            errors++;
         end
         if (got.has_byte !== exp_r.has_byte) begin
            $display("%0t: has_byte mismatch, expected %b actual %b",
                     $time, exp_r.has_byte, got.has_byte);
            errors++;
         end
         if (got.is_value !== exp_r.is_value) begin
            $display("%0t: is_value mismatch, expected %b actual %b",
                     $time, exp_r.is_value, got.is_value);
            errors++;
         end
         if (got.token_end !== exp_r.token_end) begin
            $display("%0t: token_end mismatch, expected %b actual %b",
                     $time, exp_r.token_end, got.token_end);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_push;
   logic            req_full;
   req_payload_type req_data;
   logic            rsp_empty;
   logic            rsp_pop;
   rsp_payload_type rsp_data;

   token_scoreboard sb;
   int              items_sent;
   int              cycles;
   bit              quiet;

   query_string_tokenizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_pop <= !reset && (quiet || $urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_byte(req_data);
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_data);
      end
   end

   task automatic send_item(input logic [7:0] b, input logic fin);
      quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      while (!quiet && $urandom_range(99) < 15) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data.in_byte <= b;
      req_data.in_last <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_str(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], fin && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] hex_char();
      string digits;
      int    k;
      digits = "0123456789abcdefABCDEF";
      k = $urandom_range(23);
      if (k < 22) return digits[k];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_EQUAL) b = "n";
      return b;
   endfunction

   function automatic logic [7:0] value_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if ($urandom_range(19) == 0) b = CH_EQUAL;
      else if (b == CH_AMP || b == CH_PERCENT) b = "v";
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(5))
         0: return CH_EQUAL;
         1: return CH_AMP;
         2: return CH_PERCENT;
         3: return hex_char();
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_query();
      logic [7:0] text[$];
      int         pairs;
      int         n;
      int         k;
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) text.push_back(noise_byte());
      end else begin
         pairs = $urandom_range(1, 4);
         for (int p = 0; p < pairs; p++) begin
            if (p > 0) text.push_back(CH_AMP);
            n = $urandom_range(0, 5);
            repeat (n) text.push_back(name_byte());
            if ($urandom_range(9) != 0) begin
               text.push_back(CH_EQUAL);
               n = $urandom_range(0, 6);
               repeat (n) begin
                  k = $urandom_range(99);
                  if (k < 25) begin
                     text.push_back(CH_PERCENT);
                     text.push_back(hex_char());
                     text.push_back(hex_char());
                  end else if (k < 30) begin
                     // truncated escape
                     text.push_back(CH_PERCENT);
                     if ($urandom_range(1) == 1) text.push_back(hex_char());
                  end else begin
                     text.push_back(value_byte());
                  end
               end
            end
         end
      end
      if (text.size() == 0) text.push_back(name_byte());
      foreach (text[i]) send_item(text[i], i == text.size() - 1);
   endtask

   initial begin
      sb         = new();
      items_sent = 0;
      cycles     = 0;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_push   = 1'b0;
      req_data   = '0;
      rsp_pop    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, '&' in a name, '=' in a value, non-hex digits,
      // cut-short escapes, '%' and '=' as last byte, name without '='
      send_item(8'hff, 1'b0);
      send_str("&=%41%z0=", 1'b0);
      send_item(8'h00, 1'b0);
      send_str("%7&b=%", 1'b1);
      send_str("=", 1'b1);
      send_str("=%C", 1'b1);
      send_str("n", 1'b1);
      send_str("=%aF&q", 1'b1);

      while (items_sent < ITEM_TARGET) send_random_query();
      req_push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/qst_pkg.sv
rtl/qst_front.sv
rtl/qst_queue.sv
rtl/qst_back.sv
rtl/query_string_tokenizer.sv
tb/sv/query_string_tokenizer_test.sv
